FILE: design/vfrb_pkg.sv
// vfrb_pkg: shared types and constants of the video frame reorder buffer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package vfrb_pkg;

	// input command codes
	localparam logic [1:0] CMD_ARRIVE = 2'd0;
	localparam logic [1:0] CMD_ABORT  = 2'd1;
	localparam logic [1:0] CMD_POLL   = 2'd2;
	localparam logic [1:0] CMD_RSVD   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_DELIVER = 2'd1;
	localparam logic [1:0] KIND_LOST    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_LIMIT = 2'd0;
	localparam logic [1:0] REG_BYTE_LIMIT  = 2'd1;
	localparam logic [1:0] REG_HOLD_TIME   = 2'd2;

	localparam logic [4:0]  FRAME_LIMIT_RST = 5'd16;
	localparam logic [31:0] BYTE_LIMIT_RST  = 32'hFFFF_FFFF;
	localparam logic [15:0] HOLD_TIME_RST   = 16'd100;

	localparam logic [31:0] SEQ_HALF  = 32'h8000_0000;
	localparam logic [25:0] MS_TO_US  = 26'd1000;

	typedef enum logic [1:0] {
		CLS_NOP,
		CLS_ARRIVE,
		CLS_ABORT,
		CLS_POLL
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [31:0] seq;
		logic        key;
		logic [23:0] bytes;
		logic [15:0] tag;
		logic [47:0] now;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic        key;
		logic [23:0] bytes;
		logic [15:0] tag;
		logic        last;
	} result_t;

	// per-slot removal rule applied during a table scan
	typedef enum logic [2:0] {
		FLT_NONE,
		FLT_NOT_NEWER,
		FLT_KEY_SPAN,
		FLT_EQUAL,
		FLT_EXPIRED
	} flt_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SURVEY,
		S_UA_FOUND,
		S_AN_FOUND,
		S_INSERT,
		S_UA_LIM,
		S_AN_LIM,
		S_DELIVER,
		S_LOST_AB,
		S_SKIP,
		S_DRAIN,
		S_AB_DONE,
		S_SET_GAP,
		S_POLL_CHK,
		S_FINISH
	} state_t;

endpackage

FILE: design/vfrb_front.sv
// vfrb_front: input queue of the reorder buffer; decodes the command of each item.
// Depends on vfrb_pkg.
`timescale 1ns / 1ps
module vfrb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       cmd,
	input  logic [31:0]      seq_num,
	input  logic             is_key,
	input  logic [23:0]      frame_bytes,
	input  logic [15:0]      payload_tag,
	input  logic [47:0]      now_time,
	input  logic             take,
	output logic             avail,
	output vfrb_pkg::item_t  item
);

	vfrb_pkg::item_t mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	vfrb_pkg::item_t dec;
	logic            wr;
	logic            rd;

	always_comb begin
		unique case (cmd)
			vfrb_pkg::CMD_ARRIVE: dec.cls = vfrb_pkg::CLS_ARRIVE;
			vfrb_pkg::CMD_ABORT:  dec.cls = vfrb_pkg::CLS_ABORT;
			vfrb_pkg::CMD_POLL:   dec.cls = vfrb_pkg::CLS_POLL;
			default:              dec.cls = vfrb_pkg::CLS_NOP;
		endcase
		dec.seq   = seq_num;
		dec.key   = is_key;
		dec.bytes = frame_bytes;
		dec.tag   = payload_tag;
		dec.now   = now_time;
	end

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign item  = mem_q[rp_q];
	assign wr    = push && !full;
	assign rd    = take && avail;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

FILE: design/vfrb_out_q.sv
// vfrb_out_q: two-entry result queue at the output of the reorder buffer.
// Depends on vfrb_pkg.
`timescale 1ns / 1ps
module vfrb_out_q (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  vfrb_pkg::result_t  wdata,
	output logic               ofull,
	input  logic               pop,
	output logic               empty,
	output vfrb_pkg::result_t  rdata
);

	vfrb_pkg::result_t mem_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign ofull = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !ofull;
	assign do_rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

FILE: design/vfrb_engine.sv
// vfrb_engine: slot table, sequencer and configuration registers of the reorder buffer.
// Depends on vfrb_pkg; fed by vfrb_front, feeds vfrb_out_q.
`timescale 1ns / 1ps
module vfrb_engine #(
	parameter int MAX_HELD = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               avail,
	input  vfrb_pkg::item_t    item,
	output logic               take,
	input  logic               ofull,
	output logic               owr,
	output vfrb_pkg::result_t  odata
);

	localparam int SLOTS   = MAX_HELD + 1;
	localparam int IW      = $clog2(SLOTS);
	localparam int CW      = $clog2(SLOTS + 1);
	localparam int MAX_RES = 2 * MAX_HELD + 1;
	localparam int RW      = $clog2(MAX_RES + 2);

	function automatic logic [31:0] sat_sub(input logic [31:0] h, input logic [23:0] b);
		logic [31:0] bx;
		bx = {8'd0, b};
		return (h >= bx) ? h - bx : 32'd0;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] h, input logic [23:0] b);
		logic [32:0] s;
		s = {1'b0, h} + {9'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic is_newer(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

	function automatic logic expired(input logic [47:0] now, input logic [47:0] since,
			input logic [25:0] hold);
		logic [47:0] d;
		d = now - since;
		return (now >= since) && (d >= {22'd0, hold});
	endfunction

	vfrb_pkg::state_t  state_q, state_d, ret_q, post_q;
	vfrb_pkg::item_t   it_q;
	logic              anchored_q;
	logic [31:0]       last_q;
	logic [31:0]       held_q;
	logic [47:0]       gap_q;
	logic [4:0]        flim_q;
	logic [31:0]       blim_q;
	logic [15:0]       hold_ms_q;

	logic              valid_q [SLOTS];
	logic [31:0]       sseq_q  [SLOTS];
	logic [23:0]       sbytes_q[SLOTS];
	logic [15:0]       stag_q  [SLOTS];
	logic [47:0]       sarr_q  [SLOTS];

	// scan accumulators
	logic [IW-1:0]     idx_q;
	vfrb_pkg::flt_t    flt_q;
	logic [31:0]       tgt_q;
	logic [CW-1:0]     cnt_q;
	logic              fnd_v_q, old_v_q, earl_v_q, free_v_q, rem_q;
	logic [IW-1:0]     fnd_i_q, old_i_q, free_i_q;
	logic [31:0]       old_k_q;
	logic [47:0]       earl_q;

	vfrb_pkg::result_t pend_q;
	logic              pend_v_q;
	logic [RW-1:0]     nres_q;

	// scan controls from the output decode
	logic              sv_go;
	vfrb_pkg::flt_t    sv_flt;
	logic [31:0]       sv_tgt;
	vfrb_pkg::state_t  sv_ret;
	logic              em_v;
	vfrb_pkg::result_t em_r;

	logic              ok, is_next, newer_il, over, poll_exp, hit, last_idx, room1, room2;
	logic [25:0]       hold_us;
	logic [4:0]        flim_nz;
	logic [CW-1:0]     eff;
	logic              cv;
	logic [31:0]       cs, ck;
	logic [47:0]       ca, earliest;

	assign hold_us  = 26'(hold_ms_q) * vfrb_pkg::MS_TO_US;
	assign flim_nz  = (flim_q == 5'd0) ? 5'd1 : flim_q;
	assign eff      = (32'(flim_nz) > MAX_HELD) ? CW'(MAX_HELD) : CW'(flim_nz);
	assign ok       = !(pend_v_q && ofull);
	assign is_next  = (it_q.seq == last_q + 32'd1);
	assign newer_il = is_newer(it_q.seq, last_q);
	assign over     = (cnt_q != '0) && ((cnt_q > eff) || (held_q > blim_q));
	assign poll_exp = (cnt_q != '0) && expired(it_q.now, gap_q, hold_us);
	assign earliest = earl_v_q ? earl_q : 48'd0;
	assign room1    = (32'(nres_q) < MAX_RES);
	assign room2    = (32'(nres_q) + 2 <= MAX_RES);
	assign last_idx = (idx_q == IW'(SLOTS - 1));

	assign cv = valid_q[idx_q];
	assign cs = sseq_q[idx_q];
	assign ca = sarr_q[idx_q];
	assign ck = (cs - last_q) ^ vfrb_pkg::SEQ_HALF;

	always_comb begin
		case (flt_q)
			vfrb_pkg::FLT_NOT_NEWER: hit = !is_newer(cs, it_q.seq);
			vfrb_pkg::FLT_KEY_SPAN:  hit = (cs - last_q) <= (it_q.seq - last_q);
			vfrb_pkg::FLT_EQUAL:     hit = (cs == it_q.seq);
			vfrb_pkg::FLT_EXPIRED:   hit = expired(it_q.now, ca, hold_us);
			default:                 hit = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfrb_pkg::S_IDLE: if (avail) state_d = vfrb_pkg::S_DECODE;
			vfrb_pkg::S_DECODE: begin
				unique case (it_q.cls)
					vfrb_pkg::CLS_ARRIVE: begin
						if (!anchored_q) state_d = vfrb_pkg::S_SURVEY;
						else if (is_next) state_d = vfrb_pkg::S_DELIVER;
						else if (!newer_il) state_d = vfrb_pkg::S_FINISH;
						else state_d = vfrb_pkg::S_SURVEY;
					end
					vfrb_pkg::CLS_ABORT: begin
						if (!anchored_q || (!is_next && !newer_il))
							state_d = vfrb_pkg::S_FINISH;
						else if (is_next) state_d = vfrb_pkg::S_LOST_AB;
						else state_d = vfrb_pkg::S_SURVEY;
					end
					vfrb_pkg::CLS_POLL: state_d = vfrb_pkg::S_SURVEY;
					default: state_d = vfrb_pkg::S_FINISH;
				endcase
			end
			vfrb_pkg::S_SURVEY: if (last_idx) state_d = ret_q;
			vfrb_pkg::S_UA_FOUND, vfrb_pkg::S_AN_FOUND:
				state_d = fnd_v_q ? vfrb_pkg::S_FINISH : vfrb_pkg::S_INSERT;
			vfrb_pkg::S_INSERT: state_d = vfrb_pkg::S_SURVEY;
			vfrb_pkg::S_UA_LIM: state_d = over ? vfrb_pkg::S_SURVEY : vfrb_pkg::S_FINISH;
			vfrb_pkg::S_AN_LIM: state_d = over ? vfrb_pkg::S_SKIP : vfrb_pkg::S_FINISH;
			vfrb_pkg::S_SKIP, vfrb_pkg::S_DELIVER, vfrb_pkg::S_LOST_AB:
				if (ok) state_d = vfrb_pkg::S_SURVEY;
			vfrb_pkg::S_DRAIN: begin
				if (!fnd_v_q) state_d = post_q;
				else if (ok) state_d = vfrb_pkg::S_SURVEY;
			end
			vfrb_pkg::S_AB_DONE, vfrb_pkg::S_SET_GAP: state_d = vfrb_pkg::S_FINISH;
			vfrb_pkg::S_POLL_CHK: state_d = poll_exp ? vfrb_pkg::S_SKIP : vfrb_pkg::S_FINISH;
			vfrb_pkg::S_FINISH: if (!ofull) state_d = vfrb_pkg::S_IDLE;
			default: state_d = vfrb_pkg::S_IDLE;
		endcase
	end

	// outputs: scan launch, result emission, queue handshakes
	always_comb begin
		sv_go  = 1'b0;
		sv_flt = vfrb_pkg::FLT_NONE;
		sv_tgt = it_q.seq;
		sv_ret = vfrb_pkg::S_FINISH;
		em_v   = 1'b0;
		em_r   = '0;
		take   = 1'b0;
		unique case (state_q)
			vfrb_pkg::S_IDLE: take = avail;
			vfrb_pkg::S_DECODE: begin
				unique case (it_q.cls)
					vfrb_pkg::CLS_ARRIVE: begin
						if (!anchored_q) begin
							sv_go  = 1'b1;
							sv_flt = it_q.key ? vfrb_pkg::FLT_NOT_NEWER : vfrb_pkg::FLT_NONE;
							sv_ret = it_q.key ? vfrb_pkg::S_DELIVER : vfrb_pkg::S_UA_FOUND;
						end else if (!is_next && newer_il) begin
							sv_go  = 1'b1;
							sv_flt = it_q.key ? vfrb_pkg::FLT_KEY_SPAN : vfrb_pkg::FLT_NONE;
							sv_ret = it_q.key ? vfrb_pkg::S_DELIVER : vfrb_pkg::S_AN_FOUND;
						end
					end
					vfrb_pkg::CLS_ABORT: begin
						if (anchored_q && !is_next && newer_il) begin
							sv_go  = 1'b1;
							sv_flt = vfrb_pkg::FLT_EQUAL;
							sv_ret = vfrb_pkg::S_AB_DONE;
						end
					end
					vfrb_pkg::CLS_POLL: begin
						sv_go  = 1'b1;
						sv_flt = anchored_q ? vfrb_pkg::FLT_NONE : vfrb_pkg::FLT_EXPIRED;
						sv_ret = anchored_q ? vfrb_pkg::S_POLL_CHK : vfrb_pkg::S_SET_GAP;
					end
					default: ;
				endcase
			end
			vfrb_pkg::S_INSERT: begin
				sv_go  = 1'b1;
				sv_ret = anchored_q ? vfrb_pkg::S_AN_LIM : vfrb_pkg::S_UA_LIM;
			end
			vfrb_pkg::S_UA_LIM: begin
				sv_go  = over;
				sv_ret = vfrb_pkg::S_UA_LIM;
			end
			vfrb_pkg::S_SKIP: begin
				sv_go  = ok;
				sv_tgt = sseq_q[old_i_q];
				sv_ret = vfrb_pkg::S_DRAIN;
				em_v   = ok && room2;
				em_r.kind = vfrb_pkg::KIND_LOST;
				em_r.seq  = last_q + 32'd1;
			end
			vfrb_pkg::S_DELIVER: begin
				sv_go  = ok;
				sv_tgt = it_q.seq + 32'd1;
				sv_ret = vfrb_pkg::S_DRAIN;
				em_v   = ok && room1;
				em_r.kind  = vfrb_pkg::KIND_DELIVER;
				em_r.seq   = it_q.seq;
				em_r.key   = it_q.key;
				em_r.bytes = it_q.bytes;
				em_r.tag   = it_q.tag;
			end
			vfrb_pkg::S_LOST_AB: begin
				sv_go  = ok;
				sv_tgt = it_q.seq + 32'd1;
				sv_ret = vfrb_pkg::S_DRAIN;
				em_v   = ok && room2;
				em_r.kind = vfrb_pkg::KIND_LOST;
				em_r.seq  = it_q.seq;
			end
			vfrb_pkg::S_DRAIN: begin
				sv_go  = fnd_v_q && ok;
				sv_tgt = sseq_q[fnd_i_q] + 32'd1;
				sv_ret = vfrb_pkg::S_DRAIN;
				em_v   = fnd_v_q && ok && room1;
				em_r.kind  = vfrb_pkg::KIND_DELIVER;
				em_r.seq   = sseq_q[fnd_i_q];
				em_r.bytes = sbytes_q[fnd_i_q];
				em_r.tag   = stag_q[fnd_i_q];
			end
			default: ;
		endcase

		// a new result releases the one held back; the last one waits for its flag
		owr   = 1'b0;
		odata = pend_q;
		if (state_q == vfrb_pkg::S_FINISH) begin
			owr = !ofull;
			if (pend_v_q) odata.last = 1'b1;
			else begin
				odata      = '0;
				odata.last = 1'b1;
			end
		end else if (em_v && pend_v_q) begin
			owr = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vfrb_pkg::S_IDLE;
			anchored_q <= 1'b0;
			last_q     <= 32'd0;
			held_q     <= 32'd0;
			gap_q      <= 48'd0;
			flim_q     <= vfrb_pkg::FRAME_LIMIT_RST;
			blim_q     <= vfrb_pkg::BYTE_LIMIT_RST;
			hold_ms_q  <= vfrb_pkg::HOLD_TIME_RST;
			pend_v_q   <= 1'b0;
			nres_q     <= '0;
			post_q     <= vfrb_pkg::S_FINISH;
			for (int i = 0; i < SLOTS; i++) valid_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					vfrb_pkg::REG_FRAME_LIMIT: flim_q    <= cfg_wdata[4:0];
					vfrb_pkg::REG_BYTE_LIMIT:  blim_q    <= cfg_wdata;
					vfrb_pkg::REG_HOLD_TIME:   hold_ms_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (em_v) begin
				pend_v_q <= 1'b1;
				nres_q   <= nres_q + RW'(1);
			end
			unique case (state_q)
				vfrb_pkg::S_DECODE: post_q <= vfrb_pkg::S_FINISH;
				vfrb_pkg::S_SURVEY: begin
					if (cv && hit) begin
						valid_q[idx_q] <= 1'b0;
						held_q         <= sat_sub(held_q, sbytes_q[idx_q]);
					end
				end
				vfrb_pkg::S_UA_FOUND: if (cnt_q == '0) last_q <= it_q.seq;
				vfrb_pkg::S_AN_FOUND: if (!fnd_v_q && cnt_q == '0) gap_q <= it_q.now;
				vfrb_pkg::S_INSERT: begin
					if (free_v_q) begin
						valid_q[free_i_q] <= 1'b1;
						held_q            <= sat_add(held_q, it_q.bytes);
					end
				end
				vfrb_pkg::S_UA_LIM: begin
					if (over) begin
						valid_q[old_i_q] <= 1'b0;
						held_q           <= sat_sub(held_q, sbytes_q[old_i_q]);
					end else begin
						gap_q <= earliest;
					end
				end
				vfrb_pkg::S_AN_LIM: if (over) post_q <= vfrb_pkg::S_AN_LIM;
				vfrb_pkg::S_SKIP: if (ok) last_q <= sseq_q[old_i_q] - 32'd1;
				vfrb_pkg::S_DELIVER: begin
					if (ok) begin
						anchored_q <= 1'b1;
						last_q     <= it_q.seq;
					end
				end
				vfrb_pkg::S_LOST_AB: if (ok) last_q <= it_q.seq;
				vfrb_pkg::S_DRAIN: begin
					if (fnd_v_q) begin
						if (ok) begin
							last_q           <= sseq_q[fnd_i_q];
							valid_q[fnd_i_q] <= 1'b0;
							held_q           <= sat_sub(held_q, sbytes_q[fnd_i_q]);
						end
					end else begin
						gap_q <= earliest;
					end
				end
				vfrb_pkg::S_AB_DONE: if (rem_q) gap_q <= earliest;
				vfrb_pkg::S_SET_GAP: gap_q <= earliest;
				vfrb_pkg::S_POLL_CHK: if (poll_exp) post_q <= vfrb_pkg::S_POLL_CHK;
				vfrb_pkg::S_FINISH: begin
					if (!ofull) begin
						pend_v_q <= 1'b0;
						nres_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload: item, slot contents, scan accumulators, held-back result
	always_ff @(posedge clk) begin
		if (state_q == vfrb_pkg::S_IDLE && avail) it_q <= item;
		if (em_v) pend_q <= em_r;
		if (state_q == vfrb_pkg::S_INSERT && free_v_q) begin
			sseq_q[free_i_q]   <= it_q.seq;
			sbytes_q[free_i_q] <= it_q.bytes;
			stag_q[free_i_q]   <= it_q.tag;
			sarr_q[free_i_q]   <= it_q.now;
		end
		if (sv_go) begin
			idx_q    <= '0;
			flt_q    <= sv_flt;
			tgt_q    <= sv_tgt;
			ret_q    <= sv_ret;
			cnt_q    <= '0;
			fnd_v_q  <= 1'b0;
			old_v_q  <= 1'b0;
			earl_v_q <= 1'b0;
			free_v_q <= 1'b0;
			rem_q    <= 1'b0;
		end else if (state_q == vfrb_pkg::S_SURVEY) begin
			idx_q <= idx_q + IW'(1);
			if (cv && hit) begin
				rem_q <= 1'b1;
			end else if (cv) begin
				cnt_q <= cnt_q + CW'(1);
				if (cs == tgt_q && !fnd_v_q) begin
					fnd_v_q <= 1'b1;
					fnd_i_q <= idx_q;
				end
				if (!old_v_q || ck < old_k_q) begin
					old_v_q <= 1'b1;
					old_i_q <= idx_q;
					old_k_q <= ck;
				end
				if (!earl_v_q || ca < earl_q) begin
					earl_v_q <= 1'b1;
					earl_q   <= ca;
				end
			end else if (!free_v_q) begin
				free_v_q <= 1'b1;
				free_i_q <= idx_q;
			end
		end
	end

endmodule

FILE: design/video_frame_reorder_buffer.sv
// video_frame_reorder_buffer: top level of the frame reorder buffer.
// Depends on vfrb_pkg, vfrb_front, vfrb_engine and vfrb_out_q.
`timescale 1ns / 1ps
// Usage:
//  Input channel (push/full): each item is a command. Frame arrived carries
//  seq_num, is_key, frame_bytes and payload_tag; frame aborted uses seq_num;
//  poll tick uses now_time (microseconds) to age out stale gaps. An item is
//  taken on a clock edge with push high and full low; a two-entry input queue
//  lets the next item wait while the engine works.
//  Result channel (empty/pop): delivered frames and lost reports in sequence
//  order, one or more per item, out_last high on the final one. An item that
//  causes nothing yields one result with out_kind zero.
//  Configuration (cfg_we/cfg_idx/cfg_wdata): frame limit, byte limit and hold
//  time; write only while the block is idle.
//  Timing: the engine works on one item at a time. Each lookup walks the
//  MAX_HELD+1 slots of the table one slot per cycle; every frame drained
//  or gap skipped adds one more walk.
//  Reset empties the table and restores the register defaults; no clearing
//  pass is needed. A stalled receiver backs up the two-entry result queue and
//  then freezes the engine, which in turn fills the input queue.
module video_frame_reorder_buffer #(
	parameter int MAX_HELD = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [31:0] seq_num,
	input  logic        is_key,
	input  logic [23:0] frame_bytes,
	input  logic [15:0] payload_tag,
	input  logic [47:0] now_time,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  out_kind,
	output logic [31:0] out_seq,
	output logic        out_key,
	output logic [23:0] out_bytes,
	output logic [15:0] out_tag,
	output logic        out_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	vfrb_pkg::item_t   item;
	logic              avail;
	logic              take;
	logic              ofull;
	logic              owr;
	vfrb_pkg::result_t odata;
	vfrb_pkg::result_t rdata;

	// front: accepts items and decodes the command
	vfrb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.seq_num     (seq_num),
		.is_key      (is_key),
		.frame_bytes (frame_bytes),
		.payload_tag (payload_tag),
		.now_time    (now_time),
		.take        (take),
		.avail       (avail),
		.item        (item)
	);

	// back: slot table walks, delivery and gap skipping
	vfrb_engine #(
		.MAX_HELD (MAX_HELD)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.avail     (avail),
		.item      (item),
		.take      (take),
		.ofull     (ofull),
		.owr       (owr),
		.odata     (odata)
	);

	// result queue decouples the engine from the receiver
	vfrb_out_q u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (owr),
		.wdata  (odata),
		.ofull  (ofull),
		.pop    (pop),
		.empty  (empty),
		.rdata  (rdata)
	);

	assign out_kind  = rdata.kind;
	assign out_seq   = rdata.seq;
	assign out_key   = rdata.key;
	assign out_bytes = rdata.bytes;
	assign out_tag   = rdata.tag;
	assign out_last  = rdata.last;

endmodule
